// ===== rtl/core/hashed_timer_wheel_defines.svh =====
// Assertion macros for the timer wheel.
`ifndef HASHED_TIMER_WHEEL_DEFINES_SVH
`define HASHED_TIMER_WHEEL_DEFINES_SVH
`ifndef SYNTH
// Check a condition at every clock edge out of reset.
`define HTW_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Check that a condition implies another in the same cycle.
`define HTW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define HTW_ASSERT(lbl, expr, msg)
`define HTW_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/htw_pkg.sv =====
package htw_pkg;

    localparam int WHEEL_SLOTS = 16;
    localparam int SLOT_W      = $clog2(WHEEL_SLOTS);
    localparam int NUM_TIMERS  = 32;
    localparam int ID_W        = $clog2(NUM_TIMERS);
    localparam int CNT_W       = $clog2(NUM_TIMERS + 1);
    localparam int TICK_W      = 32;
    localparam int RES_W       = 16;
    localparam logic [RES_W-1:0] RES_RESET = RES_W'(1000);

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_ADD  = 2'd1,
        CMD_DEL  = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_REJECT = 2'd1,
        ST_IGNORE = 2'd2
    } status_t;

    // One timer of the pool
    typedef struct packed {
        logic [TICK_W-1:0] rem;
        logic [ID_W-1:0]   nxt;
        logic [ID_W-1:0]   prv;
        logic [SLOT_W-1:0] slt;
    } tentry_t;

    typedef struct packed {
        logic rem;
        logic nxt;
        logic prv;
        logic slt;
    } tmask_t;

    // One slot list
    typedef struct packed {
        logic [ID_W-1:0] head;
        logic [ID_W-1:0] tail;
    } sentry_t;

    typedef struct packed {
        logic head;
        logic tail;
    } smask_t;

endpackage

// ===== rtl/core/hashed_timer_wheel.sv =====
// Hashed timing wheel with 16 slots over a pool of 32 timers. Each input
// transaction is a tick, an add, a delete or a no-op; each yields one result,
// except a tick that fires timers, which yields one result per fired timer
// (tlast on the final one). An add runs the 32-step divider that converts
// microseconds to ticks. The timer links and slot heads/tails live in two
// single-port-read synchronous memories accessed one entry per cycle.
module hashed_timer_wheel (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [15:0] cfg_wdata,     // resolution_us
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,       // command[1:0], timer_id[6:2], expiry_us[38:7]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,       // fired_id[4:0], status[6:5], running[7]
    output logic        m_tlast,
    output logic        m_tuser        // fired_valid
);
    import htw_pkg::*;

    `include "hashed_timer_wheel_defines.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_PLACE, S_AP_RD, S_AP_LINK, S_AP_ENTRY,
        S_RM_RD, S_RM_SLOT, S_RM_UPD, S_RM_MID, S_RM_DONE,
        S_TK_CHK, S_TK_HEAD, S_DR_RD, S_DR_LOAD, S_EMIT
    } state_t;

    state_t              state_reg;
    cmd_t                op_reg;
    status_t             stat_reg;
    logic [ID_W-1:0]     id_reg;
    logic [TICK_W-1:0]   ticks_reg;
    logic [SLOT_W-1:0]   cur_reg;
    logic [NUM_TIMERS-1:0]  pend_reg;
    logic [WHEEL_SLOTS-1:0] ne_reg;
    logic [CNT_W-1:0]    active_reg;
    logic [RES_W-1:0]    res_reg;
    tentry_t             e_reg;
    logic [SLOT_W-1:0]   ap_slot_reg;
    logic [TICK_W-1:0]   ap_rem_reg;
    logic [ID_W-1:0]     ap_prev_reg;
    logic [ID_W-1:0]     fh_reg;
    logic [ID_W-1:0]     ft_reg;
    logic [CNT_W-1:0]    fcnt_reg;
    logic [CNT_W-1:0]    dk_reg;
    logic [ID_W-1:0]     did_reg;

    logic                ov_reg;
    logic                ofv_reg;
    logic [ID_W-1:0]     oid_reg;
    logic                olast_reg;
    status_t             ost_reg;
    logic                orun_reg;

    // Timer and slot memories
    tentry_t             tmem [NUM_TIMERS];
    sentry_t             smem [WHEEL_SLOTS];
    tentry_t             trd_reg;
    sentry_t             srd_reg;
    logic [ID_W-1:0]     t_ra;
    logic [ID_W-1:0]     t_wa;
    tentry_t             t_wd;
    tmask_t              t_wm;
    logic [SLOT_W-1:0]   s_ra;
    logic [SLOT_W-1:0]   s_wa;
    sentry_t             s_wd;
    smask_t              s_wm;

    logic                in_acc;
    cmd_t                in_cmd;
    logic [ID_W-1:0]     in_id;
    logic                div_start;
    logic                div_done;
    logic [TICK_W-1:0]   div_q;
    logic [RES_W-1:0]    div_den;
    logic                out_free;
    logic                is_head;
    logic                is_tail;

    assign in_cmd   = cmd_t'(s_tdata[1:0]);
    assign in_id    = s_tdata[6:2];
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !ov_reg || m_tready;
    assign is_head  = srd_reg.head == id_reg;
    assign is_tail  = srd_reg.tail == id_reg;
    assign div_start = in_acc && (in_cmd == CMD_ADD) && !pend_reg[in_id];
    assign div_den   = (res_reg == '0) ? RES_W'(1) : res_reg;

    htw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (s_tdata[38:7]),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    // Write with field enables, read registered
    always_ff @(posedge clk)
    begin
        if (t_wm.rem) tmem[t_wa].rem <= t_wd.rem;
        if (t_wm.nxt) tmem[t_wa].nxt <= t_wd.nxt;
        if (t_wm.prv) tmem[t_wa].prv <= t_wd.prv;
        if (t_wm.slt) tmem[t_wa].slt <= t_wd.slt;
        trd_reg <= tmem[t_ra];
        if (s_wm.head) smem[s_wa].head <= s_wd.head;
        if (s_wm.tail) smem[s_wa].tail <= s_wd.tail;
        srd_reg <= smem[s_ra];
    end

    // Memory access per state
    always_comb
    begin
        t_ra = id_reg;
        t_wa = id_reg;
        t_wd = '0;
        t_wm = '0;
        s_ra = cur_reg;
        s_wa = ap_slot_reg;
        s_wd = '0;
        s_wm = '0;
        unique case (state_reg)
            S_AP_RD:
            begin
                s_ra = ap_slot_reg;
            end
            S_AP_LINK:
            begin
                s_wa = ap_slot_reg;
                s_wd.head = id_reg;
                s_wd.tail = id_reg;
                if (ne_reg[ap_slot_reg])
                begin
                    t_wa = srd_reg.tail;
                    t_wd.nxt = id_reg;
                    t_wm.nxt = 1'b1;
                    s_wm.tail = 1'b1;
                end
                else
                begin
                    s_wm = '{head: 1'b1, tail: 1'b1};
                end
            end
            S_AP_ENTRY:
            begin
                t_wa = id_reg;
                t_wd = '{rem: ap_rem_reg, nxt: id_reg, prv: ap_prev_reg, slt: ap_slot_reg};
                t_wm = '{rem: 1'b1, nxt: 1'b1, prv: 1'b1, slt: 1'b1};
            end
            S_RM_SLOT:
            begin
                s_ra = trd_reg.slt;
            end
            S_RM_UPD:
            begin
                s_wa = e_reg.slt;
                priority if (is_head && is_tail)
                begin
                    s_wm = '0;
                end
                else if (is_head)
                begin
                    s_wd.head = e_reg.nxt;
                    s_wm.head = 1'b1;
                    t_wa = e_reg.nxt;
                    t_wd.prv = e_reg.nxt;
                    t_wm.prv = 1'b1;
                end
                else if (is_tail)
                begin
                    s_wd.tail = e_reg.prv;
                    s_wm.tail = 1'b1;
                    t_wa = e_reg.prv;
                    t_wd.nxt = e_reg.prv;
                    t_wm.nxt = 1'b1;
                end
                else
                begin
                    t_wa = e_reg.prv;
                    t_wd.nxt = e_reg.nxt;
                    t_wm.nxt = 1'b1;
                end
            end
            S_RM_MID:
            begin
                t_wa = e_reg.nxt;
                t_wd.prv = e_reg.prv;
                t_wm.prv = 1'b1;
            end
            S_RM_DONE:
            begin
                // chain fired timers through their free next links
                t_wa = ft_reg;
                t_wd.nxt = id_reg;
                t_wm.nxt = (op_reg == CMD_TICK) && (e_reg.rem == '0) && (fcnt_reg != '0);
            end
            S_DR_RD, S_DR_LOAD:
            begin
                t_ra = did_reg;
            end
            default:
            begin
                t_ra = id_reg;
            end
        endcase
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cur_reg    <= '0;
            pend_reg   <= '0;
            ne_reg     <= '0;
            active_reg <= '0;
            res_reg    <= RES_RESET;
            fcnt_reg   <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
                res_reg <= cfg_wdata;
            if (m_tready)
                ov_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        op_reg  <= in_cmd;
                        id_reg  <= in_id;
                        unique case (in_cmd)
                            CMD_TICK:
                            begin
                                cur_reg   <= cur_reg + 1'b1;
                                fcnt_reg  <= '0;
                                state_reg <= S_TK_CHK;
                            end
                            CMD_ADD:
                            begin
                                if (pend_reg[in_id])
                                begin
                                    stat_reg  <= ST_REJECT;
                                    state_reg <= S_EMIT;
                                end
                                else
                                    state_reg <= S_DIV;
                            end
                            CMD_DEL:
                            begin
                                if (!pend_reg[in_id])
                                begin
                                    stat_reg  <= ST_IGNORE;
                                    state_reg <= S_EMIT;
                                end
                                else
                                    state_reg <= S_RM_RD;
                            end
                            default:
                            begin
                                stat_reg  <= ST_OK;
                                state_reg <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        ticks_reg  <= (div_q == '0) ? TICK_W'(1) : div_q;
                        pend_reg[id_reg] <= 1'b1;
                        active_reg <= active_reg + 1'b1;
                        state_reg  <= S_PLACE;
                    end
                end
                S_PLACE:
                begin
                    // long delays park one slot behind and lose a lap
                    if (ticks_reg >= TICK_W'(WHEEL_SLOTS))
                    begin
                        ap_rem_reg  <= ticks_reg - TICK_W'(WHEEL_SLOTS - 1);
                        ap_slot_reg <= cur_reg - 1'b1;
                    end
                    else
                    begin
                        ap_rem_reg  <= '0;
                        ap_slot_reg <= cur_reg + ticks_reg[SLOT_W-1:0];
                    end
                    state_reg <= S_AP_RD;
                end
                S_AP_RD:
                begin
                    state_reg <= S_AP_LINK;
                end
                S_AP_LINK:
                begin
                    if (ne_reg[ap_slot_reg])
                        ap_prev_reg <= srd_reg.tail;
                    else
                    begin
                        ap_prev_reg <= id_reg;
                        ne_reg[ap_slot_reg] <= 1'b1;
                    end
                    state_reg <= S_AP_ENTRY;
                end
                S_AP_ENTRY:
                begin
                    stat_reg  <= ST_OK;
                    state_reg <= (op_reg == CMD_TICK) ? S_TK_CHK : S_EMIT;
                end
                S_RM_RD:
                begin
                    state_reg <= S_RM_SLOT;
                end
                S_RM_SLOT:
                begin
                    e_reg     <= trd_reg;
                    state_reg <= S_RM_UPD;
                end
                S_RM_UPD:
                begin
                    if (is_head && is_tail)
                        ne_reg[e_reg.slt] <= 1'b0;
                    state_reg <= (!is_head && !is_tail) ? S_RM_MID : S_RM_DONE;
                end
                S_RM_MID:
                begin
                    state_reg <= S_RM_DONE;
                end
                S_RM_DONE:
                begin
                    if (op_reg == CMD_TICK && e_reg.rem != '0)
                    begin
                        ticks_reg <= e_reg.rem;
                        state_reg <= S_PLACE;
                    end
                    else
                    begin
                        pend_reg[id_reg] <= 1'b0;
                        if (active_reg != '0)
                            active_reg <= active_reg - 1'b1;
                        if (op_reg == CMD_TICK)
                        begin
                            if (fcnt_reg == '0)
                                fh_reg <= id_reg;
                            ft_reg    <= id_reg;
                            fcnt_reg  <= fcnt_reg + 1'b1;
                            state_reg <= S_TK_CHK;
                        end
                        else
                        begin
                            stat_reg  <= ST_OK;
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_TK_CHK:
                begin
                    priority if (ne_reg[cur_reg])
                        state_reg <= S_TK_HEAD;
                    else if (fcnt_reg == '0)
                    begin
                        stat_reg  <= ST_OK;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        dk_reg    <= '0;
                        did_reg   <= fh_reg;
                        state_reg <= S_DR_RD;
                    end
                end
                S_TK_HEAD:
                begin
                    id_reg    <= srd_reg.head;
                    state_reg <= S_RM_RD;
                end
                S_DR_RD:
                begin
                    state_reg <= S_DR_LOAD;
                end
                S_DR_LOAD:
                begin
                    // hand out fired timers in walk order
                    if (out_free)
                    begin
                        ov_reg    <= 1'b1;
                        ofv_reg   <= 1'b1;
                        oid_reg   <= did_reg;
                        olast_reg <= dk_reg == CNT_W'(fcnt_reg - 1'b1);
                        ost_reg   <= ST_OK;
                        orun_reg  <= active_reg != '0;
                        if (dk_reg == CNT_W'(fcnt_reg - 1'b1))
                            state_reg <= S_IDLE;
                        else
                        begin
                            dk_reg    <= dk_reg + 1'b1;
                            did_reg   <= trd_reg.nxt;
                            state_reg <= S_DR_RD;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        ov_reg    <= 1'b1;
                        ofv_reg   <= 1'b0;
                        oid_reg   <= '0;
                        olast_reg <= 1'b1;
                        ost_reg   <= stat_reg;
                        orun_reg  <= active_reg != '0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {orun_reg, ost_reg, oid_reg};
    assign m_tlast  = olast_reg;
    assign m_tuser  = ofv_reg;

    `HTW_ASSERT(a_count_match, $countones(pend_reg) == int'(active_reg), "pending count mismatch")
    `HTW_ASSERT_IMP(a_empty_wheel, active_reg == '0, ne_reg == '0, "slot list without timers")
    `HTW_ASSERT_IMP(a_fired_ok, m_tvalid && m_tuser, m_tdata[6:5] == ST_OK, "fired with status")

endmodule

// ===== rtl/core/htw_div.sv =====
module htw_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [htw_pkg::TICK_W-1:0]  dividend,
    input  logic [htw_pkg::RES_W-1:0]   divisor,
    output logic                        done,
    output logic [htw_pkg::TICK_W-1:0]  quotient
);
    import htw_pkg::*;

    localparam int STEP_W = $clog2(TICK_W + 1);

    logic [RES_W-1:0]  rem_reg;
    logic [TICK_W-1:0] quo_reg;
    logic [RES_W-1:0]  div_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [RES_W:0]    trial;
    logic              fits;

    // Shift in one dividend bit and try the subtraction
    assign trial = {rem_reg, quo_reg[TICK_W-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(TICK_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Restoring division, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? RES_W'(trial - {1'b0, div_reg}) : trial[RES_W-1:0];
            quo_reg <= {quo_reg[TICK_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== tb/sv/htw_checker.sv =====
`timescale 1ns / 1ps

module htw_checker
    import htw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tlast,
    input  logic        m_tuser,
    output int          errors,
    output int          outstanding
);

    typedef struct {
        logic            fired;
        logic [ID_W-1:0] fired_id;
        logic            last;
        status_t         status;
        logic            running;
    } wheel_result_t;

    wheel_result_t due_results[$];

    // Shadow copy of the wheel
    logic [RES_W-1:0]  res_us;
    logic [SLOT_W-1:0] now_slot;
    int unsigned       armed_count;
    logic [TICK_W-1:0] tick_left [NUM_TIMERS];
    logic [ID_W-1:0]   link_nxt  [NUM_TIMERS];
    logic [ID_W-1:0]   link_prv  [NUM_TIMERS];
    logic [SLOT_W-1:0] home_slot [NUM_TIMERS];
    logic              armed     [NUM_TIMERS];
    logic [ID_W-1:0]   slot_first[WHEEL_SLOTS];
    logic [ID_W-1:0]   slot_last [WHEEL_SLOTS];
    logic              slot_busy [WHEEL_SLOTS];

    assign outstanding = due_results.size();

    // Append a timer at the tail of a slot list
    function automatic void slot_push(logic [ID_W-1:0] t, logic [SLOT_W-1:0] s);
        if (slot_busy[s])
        begin
            link_nxt[slot_last[s]] = t;
            link_prv[t] = slot_last[s];
            slot_last[s] = t;
        end
        else
        begin
            slot_first[s] = t;
            slot_last[s] = t;
            link_prv[t] = t;
            slot_busy[s] = 1'b1;
        end
        link_nxt[t] = t;
        home_slot[t] = s;
    endfunction

    // Unlink a timer from whatever slot holds it
    function automatic void slot_pull(logic [ID_W-1:0] t);
        logic [SLOT_W-1:0] s;
        logic              at_head;
        logic              at_tail;
        s = home_slot[t];
        at_head = (slot_first[s] == t);
        at_tail = (slot_last[s] == t);
        if (at_head && at_tail)
            slot_busy[s] = 1'b0;
        else if (at_head)
        begin
            slot_first[s] = link_nxt[t];
            link_prv[link_nxt[t]] = link_nxt[t];
        end
        else if (at_tail)
        begin
            slot_last[s] = link_prv[t];
            link_nxt[link_prv[t]] = link_prv[t];
        end
        else
        begin
            link_nxt[link_prv[t]] = link_nxt[t];
            link_prv[link_nxt[t]] = link_prv[t];
        end
    endfunction

    // Pick the target slot and consume ticks: long delays park one slot behind
    function automatic logic [SLOT_W-1:0] pick_slot(logic [ID_W-1:0] t);
        logic [TICK_W-1:0] left;
        left = tick_left[t];
        if (left >= WHEEL_SLOTS)
        begin
            tick_left[t] = left - (WHEEL_SLOTS - 1);
            return now_slot - 1'b1;
        end
        tick_left[t] = '0;
        return now_slot + left[SLOT_W-1:0];
    endfunction

    function automatic void predict_item(cmd_t cmd, logic [ID_W-1:0] id,
                                         logic [31:0] expiry);
        wheel_result_t r;
        status_t       st;
        int            n;
        int            first;
        logic [15:0]   res;
        logic [31:0]   ticks;
        logic [ID_W-1:0] t;
        st = ST_OK;
        n = 0;
        first = due_results.size();
        case (cmd)
            CMD_TICK:
            begin
                now_slot = now_slot + 1'b1;
                for (int g = 0; g < 2 * NUM_TIMERS + 2 && slot_busy[now_slot]; g++)
                begin
                    t = slot_first[now_slot];
                    slot_pull(t);
                    if (tick_left[t] > 0)
                        slot_push(t, pick_slot(t));
                    else
                    begin
                        armed[t] = 1'b0;
                        if (armed_count > 0)
                            armed_count--;
                        r = '{1'b1, t, 1'b0, ST_OK, 1'b0};
                        due_results.push_back(r);
                        n++;
                    end
                end
            end
            CMD_ADD:
            begin
                if (armed[id])
                    st = ST_REJECT;
                else
                begin
                    res = (res_us == 0) ? 16'd1 : res_us;
                    ticks = expiry / res;
                    if (ticks == 0)
                        ticks = 1;
                    tick_left[id] = ticks;
                    slot_push(id, pick_slot(id));
                    armed[id] = 1'b1;
                    armed_count++;
                end
            end
            CMD_DEL:
            begin
                if (!armed[id])
                    st = ST_IGNORE;
                else
                begin
                    slot_pull(id);
                    armed[id] = 1'b0;
                    if (armed_count > 0)
                        armed_count--;
                end
            end
            default: ;
        endcase
        if (n == 0)
        begin
            r = '{1'b0, '0, 1'b0, st, 1'b0};
            due_results.push_back(r);
            n = 1;
        end
        // Running flag reflects the state after the whole item
        for (int k = first; k < due_results.size(); k++)
        begin
            due_results[k].last = (k == due_results.size() - 1);
            due_results[k].running = (armed_count > 0);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        wheel_result_t want;
        if (!rst_n)
        begin
            res_us = RES_RESET;
            now_slot = '0;
            armed_count = 0;
            for (int i = 0; i < NUM_TIMERS; i++)
                armed[i] = 1'b0;
            for (int i = 0; i < WHEEL_SLOTS; i++)
                slot_busy[i] = 1'b0;
            due_results.delete();
            errors = 0;
        end
        else
        begin
            if (cfg_wen)
                res_us = cfg_wdata;
            if (s_tvalid && s_tready)
                predict_item(cmd_t'(s_tdata[1:0]), s_tdata[6:2], s_tdata[38:7]);
            // Compare each output transaction with the oldest expectation
            if (m_tvalid && m_tready)
            begin
                if (due_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: data=%h last=%b user=%b",
                                 m_tdata, m_tlast, m_tuser);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (m_tuser !== want.fired || m_tdata[4:0] !== want.fired_id
                        || m_tlast !== want.last || m_tdata[6:5] !== want.status
                        || m_tdata[7] !== want.running)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("mismatch: exp fired=%b id=%0d last=%b st=%0d run=%b",
                                     want.fired, want.fired_id, want.last, want.status,
                                     want.running);
                            $display("          got fired=%b id=%0d last=%b st=%0d run=%b",
                                     m_tuser, m_tdata[4:0], m_tlast, m_tdata[6:5],
                                     m_tdata[7]);
                        end
                    end
                end
            end
        end
    end

endmodule

// ===== tb/sv/tb_hashed_timer_wheel.sv =====
`timescale 1ns / 1ps

module tb_hashed_timer_wheel;
    import htw_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_wen;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    int          errors;
    int          outstanding;

    int          send_idle_pct;
    int          recv_idle_pct;
    logic [15:0] res_now;

    hashed_timer_wheel dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    htw_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Stall the result channel at random
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Offer one command transaction, with random gaps ahead of it
    task automatic send_cmd(cmd_t cmd, logic [4:0] id, logic [31:0] expiry);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, expiry, id, cmd};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Drain, then write the resolution while the wheel is idle
    task automatic set_resolution(logic [15:0] value);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        cfg_wen <= 1'b1;
        cfg_wdata <= value;
        res_now = value;
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    // Adds are the commonest item and land within a few turns, so ticks keep firing
    task automatic random_item();
        int          pick;
        longint      ticks;
        longint      expiry;
        logic [15:0] res;
        pick = $urandom_range(99);
        res = (res_now == 0) ? 16'd1 : res_now;
        if (pick < 40)
        begin
            ticks = ($urandom_range(9) == 0) ? $urandom_range(60, 16) : $urandom_range(20);
            expiry = ticks * res + $urandom_range(res - 1);
            if (expiry > 32'hFFFF_FFFF)
                expiry = 32'hFFFF_FFFF;
            send_cmd(CMD_ADD, 5'($urandom_range(31)), expiry[31:0]);
        end
        else if (pick < 75)
            send_cmd(CMD_TICK, 5'($urandom_range(31)), $urandom);
        else if (pick < 90)
            send_cmd(CMD_DEL, 5'($urandom_range(31)), $urandom);
        else if (pick < 95)
            send_cmd(CMD_NONE, 5'($urandom_range(31)), $urandom);
        else
            send_cmd(cmd_t'($urandom_range(3)), 5'($urandom_range(31)), $urandom);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wen = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        send_idle_pct = 20;
        recv_idle_pct = 79;
        res_now = RES_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: minimum delay, maximum delay, rejects, FIFO order, mid-list delete
        send_cmd(CMD_ADD, 5'd0, 32'd0);
        send_cmd(CMD_ADD, 5'd31, 32'hFFFF_FFFF);
        send_cmd(CMD_ADD, 5'd0, 32'd5000);
        send_cmd(CMD_DEL, 5'd5, 32'd0);
        send_cmd(CMD_NONE, 5'd0, 32'd0);
        send_cmd(CMD_ADD, 5'd1, 32'd15000);
        send_cmd(CMD_ADD, 5'd2, 32'd16000);
        send_cmd(CMD_ADD, 5'd3, 32'd2000);
        send_cmd(CMD_ADD, 5'd4, 32'd2999);
        send_cmd(CMD_ADD, 5'd5, 32'd2000);
        send_cmd(CMD_DEL, 5'd4, 32'd0);
        send_cmd(CMD_DEL, 5'd31, 32'd0);
        repeat (13) send_cmd(CMD_TICK, 5'd0, 32'd0);

        // Random phases across resolutions and idling patterns
        set_resolution(16'd1);
        repeat (26) random_item();
        send_idle_pct = 79;
        recv_idle_pct = 20;
        set_resolution(16'hFFFF);
        repeat (26) random_item();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_resolution(16'd0);
        repeat (26) random_item();
        set_resolution(16'($urandom_range(3000, 2)));
        repeat (26) random_item();
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(12 * 600000);
        $display("== FAIL ==");
        $finish;
    end

endmodule
